// File: rtl/core/running_variance_stddev_assert.svh
// Assertion macros shared by the running variance RTL.
`ifndef RUNNING_VARIANCE_STDDEV_ASSERT_SVH
`define RUNNING_VARIANCE_STDDEV_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define RVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define RVS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/core/rvs_pkg.sv
// Shared types and constants of the running variance block.
package rvs_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned PROD_W    = 128;
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [1:0] CMD_NUM    = 2'd0;
  localparam logic [1:0] CMD_NULL   = 2'd1;
  localparam logic [1:0] CMD_NAN    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_POP_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAKE_ROOT = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SDIV,
    ST_SDIVW,
    ST_MEAN2,
    ST_MUL,
    ST_CHECK,
    ST_FINISH,
    ST_VDIVW,
    ST_SQRTS,
    ST_SQRTW,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       load_in;
    logic       decode;
    logic       load_mag;
    logic       div_start;
    logic       div_sel_var;
    logic       load_mean;
    logic       load_m2;
    logic       mul_en;
    logic       acc_en;
    logic [1:0] mul_idx;
    logic       commit;
    logic       zero_res;
    logic       load_var;
    logic       sqrt_start;
    logic       load_root;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic sample_path;
    logic eog;
    logic res_null;
    logic take_root;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/core/running_variance_stddev.sv
// Top level of the running variance and standard deviation block.
// This block keeps a running count, mean and sum of squared deviations of a
// stream of grouped Q16.16 samples using Welford's update, and on the item
// that closes a group (tlast) it returns the population or sample variance,
// or its square root, as unsigned Q48.16 together with the sample count. A
// null sample kind is skipped; a non-number kind, a full counter or an
// arithmetic overflow marks the group invalid, and an invalid, empty or
// (in sample mode) single-sample group gives a null result with value zero.
// One item is worked on at a time. Most of the work on a numeric sample is
// in the 64-step restoring divider that forms the mean step; the deviation
// product uses one 32x32 multiplier for its four partial products. Closing
// a group adds the variance division and, with take_root set, the bit-serial
// square root. The result sits in an output register, so the next input
// transaction is taken while it waits for the sink.
module running_variance_stddev #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes: index 0 population_mode, index 1 take_root.
  input  logic                          cfg_we_i,
  input  logic [rvs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                          cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [31:0]                   s_axis_tdata_i,  // [31:0] sample
  input  logic [1:0]                    s_axis_tuser_i,  // [1:0] cmd
  input  logic                          s_axis_tlast_i,  // end_of_group
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [95:0]                   m_axis_tdata_o,  // [63:0] stat_value, [95:64] sample_count
  output logic                          m_axis_tuser_o   // is_null
);
  import rvs_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [DATA_W-1:0] value;
  logic [31:0]       count;

  // The controller sequences every transaction; the datapath holds all data.
  rvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rvs_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (s_axis_tuser_i),
    .in_sample_i (s_axis_tdata_i),
    .in_eog_i    (s_axis_tlast_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_value_o (value),
    .out_null_o  (m_axis_tuser_o),
    .out_count_o (count)
  );

  assign m_axis_tdata_o = {count, value};

endmodule

// File: rtl/core/rvs_div.sv
// Restoring divider, one quotient bit per cycle.
module rvs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rvs_pkg::DATA_W-1:0] dividend_i,
  input  logic [rvs_pkg::DATA_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [rvs_pkg::DATA_W-1:0] quotient_o
);
  import rvs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W:0]   rem_q, rem_d, rem_sh;
  logic [DATA_W-1:0] quo_q, quo_d, den_q, den_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DATA_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d    = rem_sh - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = rem_sh;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/core/rvs_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module rvs_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rvs_pkg::PROD_W-1:0] radicand_i,
  output logic                      done_o,
  output logic [rvs_pkg::DATA_W-1:0] root_o
);
  import rvs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W + 1);
  localparam int unsigned REM_W = DATA_W + 2;

  logic [PROD_W-1:0] rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [DATA_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[REM_W-3:0], rad_q[PROD_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[PROD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: rtl/core/rvs_ctrl.sv
// Sequencer that steps the datapath through one item.
module rvs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rvs_pkg::dp_stat_t stat_i,
  output rvs_pkg::dp_cmd_t  cmd_o
);
  import rvs_pkg::*;

  `include "running_variance_stddev_assert.svh"

  state_e     state_q, state_d;
  logic [2:0] mul_cnt_q, mul_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mul_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      mul_cnt_q <= mul_cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mul_cnt_d  = '0;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        cmd_o.decode   = 1'b1;
        cmd_o.load_mag = 1'b1;
        state_d = stat_i.sample_path ? ST_SDIV : ST_FINISH;
      end
      ST_SDIV: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_SDIVW;
      end
      ST_SDIVW: begin
        if (stat_i.div_done) begin
          cmd_o.load_mean = 1'b1;
          state_d = ST_MEAN2;
        end
      end
      ST_MEAN2: begin
        cmd_o.load_m2 = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en  = (mul_cnt_q < 3'd4);
        cmd_o.acc_en  = (mul_cnt_q != 3'd0);
        cmd_o.mul_idx = mul_cnt_q[1:0];
        mul_cnt_d     = mul_cnt_q + 3'd1;
        if (mul_cnt_q == 3'd4) begin
          mul_cnt_d = '0;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.commit = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat_i.eog) begin
          state_d = ST_IDLE;
        end else if (stat_i.res_null) begin
          cmd_o.zero_res = 1'b1;
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_start   = 1'b1;
          cmd_o.div_sel_var = 1'b1;
          state_d = ST_VDIVW;
        end
      end
      ST_VDIVW: begin
        if (stat_i.div_done) begin
          cmd_o.load_var = 1'b1;
          state_d = stat_i.take_root ? ST_SQRTS : ST_EMIT;
        end
      end
      ST_SQRTS: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = ST_SQRTW;
      end
      ST_SQRTW: begin
        if (stat_i.sqrt_done) begin
          cmd_o.load_root = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `RVS_ASSERT(a_div_start_waits, cmd_o.div_start |=> (state_q == ST_SDIVW || state_q == ST_VDIVW), "divider started without a wait state")
  `RVS_ASSERT(a_out_only_when_free, cmd_o.load_out |-> stat_i.out_free, "result loaded over a pending transaction")
  `RVS_ASSERT(a_root_only_when_asked, cmd_o.sqrt_start |-> stat_i.take_root, "square root started in variance mode")

endmodule

// File: rtl/core/rvs_dp.sv
// Datapath: group state, Welford update, multiplier and result register.
module rvs_dp #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rvs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                         cfg_wdata_i,
  input  logic [1:0]                   in_cmd_i,
  input  logic [31:0]                  in_sample_i,
  input  logic                         in_eog_i,
  input  rvs_pkg::dp_cmd_t             cmd_i,
  output rvs_pkg::dp_stat_t            stat_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [rvs_pkg::DATA_W-1:0]   out_value_o,
  output logic                         out_null_o,
  output logic [31:0]                  out_count_o
);
  import rvs_pkg::*;

  logic                   pop_q, root_q;
  logic [1:0]             cmd_q;
  logic [DATA_W-1:0]      x_q, mean_q, sum_q, mag_q, mnew_q, m2_q, pp_q, res_q;
  logic                   eog_q, neg_q, inv_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [1:0]             pp_sh_q;
  logic [PROD_W-1:0]      acc_q;
  logic                   ov_q, onull_q;
  logic [DATA_W-1:0]      oval_q;
  logic [31:0]            ocnt_q;

  logic [DATA_W-1:0]   raw64, x_ext, d_pos, d_neg, d2_pos, d2_neg, step, count64;
  logic [DATA_W-1:0]   div_a, div_b, quo, root;
  logic                div_done, sqrt_done, count_full, res_null;
  logic [HALF_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]   p_sh;
  logic [DATA_W:0]     sum_new;
  logic                mul_ovf;

  function automatic logic in_cmd_q_bad(input logic [1:0] c);
    in_cmd_q_bad = (c != CMD_NUM) && (c != CMD_NULL);
  endfunction

  assign raw64      = DATA_W'(in_sample_i);
  assign x_ext      = DATA_W'($signed(raw64[SAMPLE_WIDTH-1:0]));
  assign count64    = DATA_W'(count_q);
  assign count_full = &count_q;
  assign res_null   = inv_q || (count_q == '0) || (count_q == COUNT_WIDTH'(1) && !pop_q);

  // Magnitude of x - mean without a negate after the subtract.
  assign d_pos  = x_q - mean_q;
  assign d_neg  = mean_q - x_q;
  assign d2_pos = x_q - mnew_q;
  assign d2_neg = mnew_q - x_q;
  assign step   = neg_q ? (DATA_W'(0) - quo) : quo;

  assign div_a = cmd_i.div_sel_var ? sum_q : mag_q;
  assign div_b = cmd_i.div_sel_var ? (pop_q ? count64 : count64 - DATA_W'(1))
                                   : count64 + DATA_W'(1);

  assign mul_a = cmd_i.mul_idx[0] ? mag_q[DATA_W-1 -: HALF_W] : mag_q[HALF_W-1:0];
  assign mul_b = cmd_i.mul_idx[1] ? m2_q[DATA_W-1 -: HALF_W] : m2_q[HALF_W-1:0];

  assign p_sh    = acc_q >> FRAC_BITS;
  assign mul_ovf = |p_sh[PROD_W-1:DATA_W];
  assign sum_new = {1'b0, sum_q} + {1'b0, p_sh[DATA_W-1:0]};

  rvs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  rvs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (PROD_W'(res_q) << FRAC_BITS),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // Group state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q   <= 1'b1;
      root_q  <= 1'b0;
      count_q <= '0;
      mean_q  <= '0;
      sum_q   <= '0;
      inv_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_POP_MODE)  pop_q  <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == REG_TAKE_ROOT) root_q <= cfg_wdata_i;
      if (cmd_i.decode && !inv_q) begin
        if (in_cmd_q_bad(cmd_q) || (cmd_q == CMD_NUM && count_full)) inv_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        if (mul_ovf || sum_new[DATA_W]) begin
          inv_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
          mean_q  <= mnew_q;
          sum_q   <= sum_new[DATA_W-1:0];
        end
      end
      if (cmd_i.load_out) begin
        count_q <= '0;
        mean_q  <= '0;
        sum_q   <= '0;
        inv_q   <= 1'b0;
        ov_q    <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Working registers of one update and the result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= in_cmd_i;
      x_q   <= x_ext;
      eog_q <= in_eog_i;
    end
    if (cmd_i.load_mag) begin
      neg_q <= d_pos[DATA_W-1];
      mag_q <= d_pos[DATA_W-1] ? d_neg : d_pos;
    end
    if (cmd_i.load_mean) mnew_q <= mean_q + step;
    if (cmd_i.load_m2) begin
      m2_q  <= d2_pos[DATA_W-1] ? d2_neg : d2_pos;
      acc_q <= '0;
    end
    if (cmd_i.mul_en) begin
      pp_q    <= DATA_W'(mul_a) * DATA_W'(mul_b);
      pp_sh_q <= 2'(cmd_i.mul_idx[0]) + 2'(cmd_i.mul_idx[1]);
    end
    if (cmd_i.acc_en) acc_q <= acc_q + (PROD_W'(pp_q) << (HALF_W * pp_sh_q));
    if (cmd_i.zero_res)  res_q <= '0;
    if (cmd_i.load_var)  res_q <= quo;
    if (cmd_i.load_root) res_q <= root;
    if (cmd_i.load_out) begin
      oval_q  <= res_q;
      onull_q <= res_null;
      ocnt_q  <= count64[31:0];
    end
  end

  assign stat_o.sample_path = !inv_q && (cmd_q == CMD_NUM) && !count_full;
  assign stat_o.eog         = eog_q;
  assign stat_o.res_null    = res_null;
  assign stat_o.take_root   = root_q;
  assign stat_o.div_done    = div_done;
  assign stat_o.sqrt_done   = sqrt_done;
  assign stat_o.out_free    = !ov_q || out_ready_i;

  assign out_valid_o = ov_q;
  assign out_value_o = oval_q;
  assign out_null_o  = onull_q;
  assign out_count_o = ocnt_q;

endmodule
